// File: rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the circular FIFO queue unit.
// ----------------------------------------------------------------------------
package cfq_pkg;

    // Word width held by each storage cell
    localparam int unsigned DATA_W = 32;

    // Width of the count and queue size fields at the ports
    localparam int unsigned CNT_W = 4;

    // Packed result word: read_value, count, is_empty, is_full, zero fill
    localparam int unsigned OUT_TDATA_W = 40;

    // Command codes carried on the request side tuser
    typedef enum logic {
        t_cmd_enq = 1'b0,
        t_cmd_deq = 1'b1
    } t_cmd;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic shift;   // dequeue: take the neighbour's word
        logic load;    // enqueue: this cell is the free slot behind the tail
    } t_cell_ctrl;

endpackage

// File: rtl/cfq_cell.sv
// ----------------------------------------------------------------------------
// cfq_cell
// One storage slot of the queue chain. Shifts towards the head on a dequeue
// and captures the incoming word when it is the first free slot.
// ----------------------------------------------------------------------------
module cfq_cell (
    input  logic                        i_clk,
    input  cfq_pkg::t_cell_ctrl         i_ctrl,
    input  logic [cfq_pkg::DATA_W-1:0]  i_next_data,
    input  logic [cfq_pkg::DATA_W-1:0]  i_wr_data,
    output logic [cfq_pkg::DATA_W-1:0]  o_data
);

    logic [cfq_pkg::DATA_W-1:0] r_data;
    logic [cfq_pkg::DATA_W-1:0] n_data;

    // Select the next word: neighbour on shift, request word on load, else hold
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift) begin
            n_data = i_next_data;
        end else if (i_ctrl.load) begin
            n_data = i_wr_data;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: rtl/circular_fifo_queue_unit.sv
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit
// FIFO of signed 32-bit words with a run-time logical capacity, built as a
// chain of storage cells with the head at cell zero.
// ----------------------------------------------------------------------------
// Each request is an enqueue or a dequeue and yields exactly one result,
// captured in an output register and held there until the downstream side
// accepts it. One request per clock is sustained: s_axis_tready is low only
// while a result is held and m_axis_tready is low. A dequeue moves every
// cell one place towards the head in the same cycle; an enqueue writes the
// cell just behind the last entry, so the single count register sets both the
// write position and the flags. Writing the size register (values 0 and
// above DEPTH are clamped to 1 and DEPTH) empties the queue; it takes no
// clearing pass, since stale cell contents are never returned. DEPTH may be
// set from 1 to 15.
// ----------------------------------------------------------------------------
module circular_fifo_queue_unit #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Size register write
    input  logic                             i_cfg_we,
    input  logic [cfq_pkg::CNT_W-1:0]        i_cfg_wdata,
    // Request side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cfq_pkg::DATA_W-1:0]       s_axis_tdata,  // [31:0] write_value
    input  logic                             s_axis_tuser,  // [0] cmd
    // Result side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] read_value, [35:32] count, [36] is_empty, [37] is_full, [39:38] 0
    output logic [cfq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser   // [0] ok
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned RST_SIZE = (DEPTH < 8) ? DEPTH : 8;

    // Queue state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_qsize;
    logic [CW-1:0] n_qsize;

    // Result register
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic                        r_out_ok;
    logic                        n_out_ok;
    logic [cfq_pkg::DATA_W-1:0]  r_out_rdata;
    logic [cfq_pkg::DATA_W-1:0]  n_out_rdata;
    logic [CW-1:0]               r_out_count;
    logic [CW-1:0]               n_out_count;
    logic                        r_out_empty;
    logic                        n_out_empty;
    logic                        r_out_full;
    logic                        n_out_full;

    logic                        req_accept;
    logic                        do_enq;
    logic                        do_deq;
    cfq_pkg::t_cmd               req_cmd;

    cfq_pkg::t_cell_ctrl         cell_ctrl [DEPTH];
    logic [cfq_pkg::DATA_W-1:0]  cell_data [DEPTH];
    logic [cfq_pkg::DATA_W-1:0]  cell_next [DEPTH];

    // Decode the request
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign req_cmd       = cfq_pkg::t_cmd'(s_axis_tuser);
    assign do_enq = req_accept && (req_cmd == cfq_pkg::t_cmd_enq) && (r_count < r_qsize);
    assign do_deq = req_accept && (req_cmd == cfq_pkg::t_cmd_deq) && (r_count != '0);

    // Advance the count and clamp size register writes
    always_comb begin
        n_count = r_count;
        n_qsize = r_qsize;
        if (i_cfg_we) begin
            n_count = '0;
            if (i_cfg_wdata == '0) begin
                n_qsize = CW'(1);
            end else if (i_cfg_wdata > cfq_pkg::CNT_W'(DEPTH)) begin
                n_qsize = CW'(DEPTH);
            end else begin
                n_qsize = CW'(i_cfg_wdata);
            end
        end else if (do_enq) begin
            n_count = r_count + CW'(1);
        end else if (do_deq) begin
            n_count = r_count - CW'(1);
        end
    end

    // Build the result of the request taken this cycle
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_rdata = r_out_rdata;
        n_out_count = r_out_count;
        n_out_empty = r_out_empty;
        n_out_full  = r_out_full;
        if (req_accept) begin
            n_out_valid = 1'b1;
            n_out_ok    = do_enq || do_deq;
            n_out_rdata = do_deq ? cell_data[0] : '0;
            n_out_count = n_count;
            n_out_empty = (n_count == '0);
            n_out_full  = (n_count == r_qsize);
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_qsize     <= CW'(RST_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_qsize     <= n_qsize;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_out_ok;
        r_out_rdata <= n_out_rdata;
        r_out_count <= n_out_count;
        r_out_empty <= n_out_empty;
        r_out_full  <= n_out_full;
    end

    // Chain of storage cells, head at cell zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == DEPTH - 1) begin : g_last
            assign cell_next[g] = cell_data[g];
        end else begin : g_mid
            assign cell_next[g] = cell_data[g+1];
        end

        assign cell_ctrl[g].shift = do_deq;
        assign cell_ctrl[g].load  = do_enq && (r_count == CW'(g));

        cfq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl[g]),
            .i_next_data (cell_next[g]),
            .i_wr_data   (s_axis_tdata),
            .o_data      (cell_data[g])
        );
    end

    // Drive the result port
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {2'b00, r_out_full, r_out_empty,
                            cfq_pkg::CNT_W'(r_out_count), r_out_rdata};

`ifndef SYNTHESIS
    // Count never exceeds the logical capacity
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_qsize)
        else $error("queue count above capacity");

    // Enqueue with room succeeds and reports one more entry
    a_enq_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && !i_cfg_we && (req_cmd == cfq_pkg::t_cmd_enq)
         && (r_count < r_qsize))
        |=> (m_axis_tvalid && m_axis_tuser && (r_count == $past(r_count) + CW'(1))))
        else $error("enqueue with room not taken");

    // Dequeue on empty is refused with a zero word
    a_deq_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && !i_cfg_we && (req_cmd == cfq_pkg::t_cmd_deq) && (r_count == '0))
        |=> (m_axis_tvalid && !m_axis_tuser && (r_out_rdata == '0) && r_out_empty))
        else $error("dequeue on empty not refused cleanly");

    // Without a request or size write the count holds
    a_count_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!req_accept && !i_cfg_we) |=> $stable(r_count))
        else $error("count moved without a request");
`endif

endmodule
